// ===== sv/pd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pd_pkg;

  // escape introducer
  localparam logic [7:0] PCT_CHAR = 8'h25;

  // decoded-op queue between the front and the back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // pending escape state
  localparam logic [1:0] PEND_NONE  = 2'd0;
  localparam logic [1:0] PEND_PCT   = 2'd1;
  localparam logic [1:0] PEND_DIGIT = 2'd2;

  // one decoded op: one to three result bytes, last flag on the final one
  typedef struct packed {
    logic [1:0] count;
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
    logic       last;
  } pd_op_t;

  // bit 4 set when the character is not a hex digit, else the nibble below
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    v = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = {1'b0, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = {1'b0, 4'(c - 8'h61 + 8'd10)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = {1'b0, 4'(c - 8'h41 + 8'd10)};
    end
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== sv/percent_decoder_unit.sv =====
// A result item is written to the op queue, then loaded into the output register that shows it.
// Throughput: one input item per cycle unless full; one result item per cycle when popped.
// An item giving two or three results holds the back end until each result is loaded; the
// four-entry op queue between front and back absorbs the difference.
// Reset (rst, synchronous, active high) clears the held escape, the queue and the output.
`timescale 1ns / 1ps
`default_nettype none

module percent_decoder_unit import pd_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_last,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      out_byte,
  output logic            out_last
);

  pd_op_t front_op;
  pd_op_t head_op;
  logic   front_valid;
  logic   accept;
  logic   q_not_empty;
  logic   q_full;
  logic   op_done;

  assign full   = q_full;
  assign accept = push && !q_full;

  pd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .op       (front_op),
    .op_valid (front_valid)
  );

  pd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .wr        (front_valid),
    .wr_op     (front_op),
    .rd        (op_done),
    .rd_op     (head_op),
    .not_empty (q_not_empty),
    .is_full   (q_full)
  );

  pd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .op       (head_op),
    .op_avail (q_not_empty),
    .op_done  (op_done),
    .pop      (pop),
    .empty    (empty),
    .out_byte (out_byte),
    .out_last (out_last)
  );

endmodule

`default_nettype wire

// ===== sv/pd_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pd_front import pd_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       accept,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_last,
  output pd_op_t          op,
  output logic            op_valid
);

  logic [1:0] pending_count;
  logic [1:0] pending_count_next;
  logic [7:0] pending_digit;
  logic [7:0] pending_digit_next;

  logic [4:0] v;
  logic [4:0] hi;
  logic       fresh;
  logic       fresh_hold;
  logic [1:0] pre_n;
  logic [7:0] pre0;
  logic [7:0] pre1;

  assign v          = hex_value(in_byte);
  assign hi         = hex_value(pending_digit);
  assign fresh_hold = (in_byte == PCT_CHAR) && !in_last;

  // classify the byte against what is held
  always_comb begin
    pending_count_next = PEND_NONE;
    pending_digit_next = pending_digit;
    fresh              = 1'b0;
    pre_n              = 2'd0;
    pre0               = PCT_CHAR;
    pre1               = pending_digit;
    op                 = '0;
    op.last            = in_last;
    case (pending_count)
      PEND_PCT: begin
        if (!v[4]) begin
          if (in_last) begin
            op.count = 2'd2;
            op.byte0 = PCT_CHAR;
            op.byte1 = in_byte;
          end else begin
            pending_digit_next = in_byte;
            pending_count_next = PEND_DIGIT;
          end
        end else begin
          pre_n = 2'd1;
          fresh = 1'b1;
        end
      end
      PEND_DIGIT: begin
        if (!v[4]) begin
          op.count = 2'd1;
          op.byte0 = {hi[3:0], v[3:0]};
        end else begin
          pre_n = 2'd2;
          fresh = 1'b1;
        end
      end
      default: begin
        fresh = 1'b1;
      end
    endcase

    // flushed prefix followed by the byte taken afresh, unless that byte opens a new escape
    if (fresh) begin
      op.byte0 = pre0;
      op.byte1 = pre1;
      if (fresh_hold) begin
        pending_count_next = PEND_PCT;
        op.count           = pre_n;
      end else begin
        op.count = pre_n + 2'd1;
        case (pre_n)
          2'd0:    op.byte0 = in_byte;
          2'd1:    op.byte1 = in_byte;
          default: op.byte2 = in_byte;
        endcase
      end
    end
  end

  assign op_valid = accept && (op.count != 2'd0);

  // pending escape registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_count <= PEND_NONE;
      pending_digit <= '0;
    end else if (accept) begin
      pending_count <= pending_count_next;
      pending_digit <= pending_digit_next;
    end
  end

endmodule

`default_nettype wire

// ===== sv/pd_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pd_queue import pd_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   wr,
  input  wire pd_op_t wr_op,
  input  wire logic   rd,
  output pd_op_t      rd_op,
  output logic        not_empty,
  output logic        is_full
);

  pd_op_t            mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign rd_op     = mem[rd_ptr];
  assign not_empty = (count != '0);
  assign is_full   = (count == (QPTR_W+1)'(QUEUE_DEPTH));

  // op storage
  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= wr_op;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (wr && !rd) begin
        count <= count + 1'b1;
      end else if (rd && !wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/pd_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pd_back import pd_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire pd_op_t     op,
  input  wire logic       op_avail,
  output logic            op_done,
  input  wire logic       pop,
  output logic            empty,
  output logic [7:0]      out_byte,
  output logic            out_last
);

  logic       out_valid;
  logic [1:0] idx;
  logic       load;
  logic       final_byte;
  logic [7:0] sel_byte;

  assign empty      = !out_valid;
  assign load       = op_avail && (!out_valid || pop);
  assign final_byte = (idx == op.count - 2'd1);
  assign op_done    = load && final_byte;

  // pick the byte of the head op
  always_comb begin
    case (idx)
      2'd0:    sel_byte = op.byte0;
      2'd1:    sel_byte = op.byte1;
      default: sel_byte = op.byte2;
    endcase
  end

  // output register and byte index within the op
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= final_byte ? 2'd0 : idx + 2'd1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte <= sel_byte;
      out_last <= op.last && final_byte;
    end
  end

endmodule

`default_nettype wire

// ===== sv/pd_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pd_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       push,
  input wire logic       full,
  input wire logic [7:0] in_byte,
  input wire logic       in_last,
  input wire logic       empty,
  input wire logic       pop,
  input wire logic [7:0] out_byte,
  input wire logic       out_last
);

  // reset leaves no result waiting
  a_rst_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result shown after reset");

  // reset leaves the input side open
  a_rst_open: assert property (@(posedge clk) rst |=> !full)
    else $error("full after reset");

  // a waiting item holds until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(out_last)))
    else $error("waiting item changed");

  // an item closing the text always yields a result once through the op queue and output register
  a_last_result: assert property (@(posedge clk) disable iff (rst)
    (push && !full && in_last && empty && !pop) |=> ##1 (!empty || $past(rst)))
    else $error("end of text gave no result");

endmodule

bind percent_decoder_unit pd_checker u_pd_checker (
  .clk      (clk),
  .rst      (rst),
  .push     (push),
  .full     (full),
  .in_byte  (in_byte),
  .in_last  (in_last),
  .empty    (empty),
  .pop      (pop),
  .out_byte (out_byte),
  .out_last (out_last)
);

`default_nettype wire
